FILE: rtl/cube_dir_to_face_uv_macros.svh
// ----------------------------------------------------------------------------
// cube_dir_to_face_uv_macros.svh
// Assertion macros used by the cube face selection checker.
// ----------------------------------------------------------------------------
`ifndef CUBE_DIR_TO_FACE_UV_MACROS_SVH
`define CUBE_DIR_TO_FACE_UV_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define CDU_ASSERT_IMPLY(name, clk, rst_n, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define CDU_ASSERT_NEXT(name, clk, rst_n, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: rtl/cdu_pkg.sv
// ----------------------------------------------------------------------------
// cdu_pkg
// Face codes and the per-item tag shared by the cube face selection block.
// ----------------------------------------------------------------------------
package cdu_pkg;

    // Cube face numbering
    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // Classification result that travels with each item
    typedef struct packed {
        face_t face;
        logic  degenerate;
    } cdu_tag_t;

    // Entries in the queue between classifier and divider
    localparam int unsigned QUEUE_DEPTH = 4;

endpackage

FILE: rtl/cube_dir_to_face_uv.sv
// ----------------------------------------------------------------------------
// cube_dir_to_face_uv
// Cube map face selection and face coordinates from a fixed-point direction.
// ----------------------------------------------------------------------------
// One direction vector is accepted per clock and one result per clock leaves,
// in order, while the output is not stalled. The path runs through one
// classify register, the four-entry queue, COORD_WIDTH + 1 divider stages (an
// integer-digit stage, then stages that each resolve one fractional quotient
// bit for both coordinates), and the output register. The divider pipeline
// takes a new item every cycle unless the output is stalled. When the output
// is stalled the divider holds, the queue fills, and s_tready drops once the
// queue and the classify register are full. A zero vector returns face -x,
// both coordinates at one half, and the degenerate flag in m_tuser.
// ----------------------------------------------------------------------------
module cube_dir_to_face_uv import cdu_pkg::*;
#(
    parameter int COMP_WIDTH  = 16,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // dir_x, dir_y, dir_z
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0]            s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // face_index, coord_u, coord_v
    output logic [((3+2*COORD_WIDTH+7)/8)*8-1:0]         m_tdata,
    // degenerate
    output logic [0:0]                                   m_tuser
);

    localparam int RW          = COMP_WIDTH + 1;
    localparam int TAG_W       = $bits(cdu_tag_t);
    localparam int ENTRY_W     = TAG_W + 3 * RW;
    localparam int OUT_TDATA_W = ((3 + 2 * COORD_WIDTH + 7) / 8) * 8;

    logic                   push_valid, queue_full;
    cdu_tag_t               push_tag;
    logic [RW-1:0]          push_dist, push_num_u, push_num_v;
    logic [ENTRY_W-1:0]     push_entry, head_entry;
    logic                   head_valid, head_pop;
    cdu_tag_t               head_tag;
    logic [RW-1:0]          head_dist, head_num_u, head_num_v;
    face_t                  face_index;
    logic [COORD_WIDTH-1:0] coord_u, coord_v;
    logic                   degenerate;

    // Classify
    cdu_front #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .dir_x      (s_tdata[COMP_WIDTH-1:0]),
        .dir_y      (s_tdata[2*COMP_WIDTH-1:COMP_WIDTH]),
        .dir_z      (s_tdata[3*COMP_WIDTH-1:2*COMP_WIDTH]),
        .push_valid (push_valid),
        .queue_full (queue_full),
        .push_tag   (push_tag),
        .push_dist  (push_dist),
        .push_num_u (push_num_u),
        .push_num_v (push_num_v)
    );

    // Decouple classifier and divider
    assign push_entry = {push_tag, push_dist, push_num_u, push_num_v};

    cdu_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_entry),
        .full      (queue_full),
        .pop       (head_pop),
        .pop_valid (head_valid),
        .pop_data  (head_entry)
    );

    assign head_tag   = head_entry[ENTRY_W-1:3*RW];
    assign head_dist  = head_entry[3*RW-1:2*RW];
    assign head_num_u = head_entry[2*RW-1:RW];
    assign head_num_v = head_entry[RW-1:0];

    // Divide, round and register the result
    cdu_back #(
        .COMP_WIDTH  (COMP_WIDTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (head_valid),
        .in_pop     (head_pop),
        .in_tag     (head_tag),
        .in_dist    (head_dist),
        .in_num_u   (head_num_u),
        .in_num_v   (head_num_v),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .face_index (face_index),
        .coord_u    (coord_u),
        .coord_v    (coord_v),
        .degenerate (degenerate)
    );

    // Pack the result, zero filled to whole bytes
    assign m_tdata = OUT_TDATA_W'({coord_v, coord_u, face_index});
    assign m_tuser = degenerate;

endmodule

FILE: rtl/cdu_front.sv
// ----------------------------------------------------------------------------
// cdu_front
// Accepts direction vectors, picks the major axis and face, and forms the
// divisor and the two offset numerators for the divider.
// ----------------------------------------------------------------------------
module cdu_front import cdu_pkg::*;
#(
    parameter int COMP_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic signed [COMP_WIDTH-1:0] dir_x,
    input  logic signed [COMP_WIDTH-1:0] dir_y,
    input  logic signed [COMP_WIDTH-1:0] dir_z,
    output logic                         push_valid,
    input  logic                         queue_full,
    output cdu_tag_t                     push_tag,
    output logic [COMP_WIDTH:0]          push_dist,
    output logic [COMP_WIDTH:0]          push_num_u,
    output logic [COMP_WIDTH:0]          push_num_v
);

    typedef logic [COMP_WIDTH-1:0]        mag_t;
    typedef logic signed [COMP_WIDTH:0]   ext_t;
    typedef logic [COMP_WIDTH:0]          uext_t;

    mag_t     abs_x, abs_y, abs_z;
    ext_t     ext_x, ext_y, ext_z;
    logic     pos_x, pos_y, pos_z;
    logic     is_zero;
    cdu_tag_t tag_next;
    ext_t     major_next, num_u_next, num_v_next;

    logic     front_valid_reg, front_valid_next;
    cdu_tag_t tag_reg;
    ext_t     major_reg, num_u_reg, num_v_reg;
    logic     load;

    ext_t     divisor;
    ext_t     off_u, off_v;

    // Magnitudes and sign-extended components
    assign abs_x = dir_x[COMP_WIDTH-1] ? mag_t'(-dir_x) : mag_t'(dir_x);
    assign abs_y = dir_y[COMP_WIDTH-1] ? mag_t'(-dir_y) : mag_t'(dir_y);
    assign abs_z = dir_z[COMP_WIDTH-1] ? mag_t'(-dir_z) : mag_t'(dir_z);
    assign ext_x = ext_t'(dir_x);
    assign ext_y = ext_t'(dir_y);
    assign ext_z = ext_t'(dir_z);
    assign pos_x = !dir_x[COMP_WIDTH-1] && (dir_x != '0);
    assign pos_y = !dir_y[COMP_WIDTH-1] && (dir_y != '0);
    assign pos_z = !dir_z[COMP_WIDTH-1] && (dir_z != '0);
    assign is_zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);

    // Pick the major axis (ties prefer x, then y) and the face-signed numerators
    always_comb
    begin
        tag_next.degenerate = is_zero;
        priority if ((abs_x >= abs_y) && (abs_x >= abs_z))
        begin
            major_next    = ext_x;
            num_u_next    = ext_z;
            tag_next.face = pos_x ? FACE_POS_X : FACE_NEG_X;
            num_v_next    = pos_x ? ext_y : -ext_y;
        end
        else if (abs_y >= abs_z)
        begin
            major_next    = ext_y;
            num_u_next    = ext_x;
            tag_next.face = pos_y ? FACE_POS_Y : FACE_NEG_Y;
            num_v_next    = pos_y ? ext_z : -ext_z;
        end
        else
        begin
            major_next    = ext_z;
            num_u_next    = -ext_x;
            tag_next.face = pos_z ? FACE_POS_Z : FACE_NEG_Z;
            num_v_next    = pos_z ? ext_y : -ext_y;
        end
    end

    // Take a transaction whenever the stage is empty or drains into the queue
    assign s_tready = !front_valid_reg || !queue_full;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (s_tready)
        begin
            front_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tag_reg   <= tag_next;
            major_reg <= major_next;
            num_u_reg <= num_u_next;
            num_v_reg <= num_v_next;
        end
    end

    // Fold the divisor sign into the numerators and offset them into [0, 2d];
    // the face choice keeps each numerator within the divisor magnitude
    assign divisor = major_reg[COMP_WIDTH] ? -major_reg : major_reg;
    assign off_u   = (major_reg[COMP_WIDTH] ? -num_u_reg : num_u_reg) + divisor;
    assign off_v   = (major_reg[COMP_WIDTH] ? -num_v_reg : num_v_reg) + divisor;

    assign push_valid = front_valid_reg;
    assign push_tag   = tag_reg;
    assign push_dist  = uext_t'(divisor);
    assign push_num_u = uext_t'(off_u);
    assign push_num_v = uext_t'(off_v);

endmodule

FILE: rtl/cdu_queue.sv
// ----------------------------------------------------------------------------
// cdu_queue
// Short register queue that decouples the classifier from the divider.
// ----------------------------------------------------------------------------
module cdu_queue import cdu_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    typedef logic [PW-1:0]   ptr_t;
    typedef logic [CNTW-1:0] cnt_t;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    ptr_t             wr_ptr_reg, wr_ptr_next;
    ptr_t             rd_ptr_reg, rd_ptr_next;
    cnt_t             count_reg, count_next;
    logic             do_push, do_pop;

    function automatic ptr_t ptr_inc(input ptr_t ptr);
        return (ptr == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(ptr + 1'b1);
    endfunction

    assign full      = (count_reg == cnt_t'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = cnt_t'(count_reg + 1'b1);
            2'b01:   count_next = cnt_t'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/cdu_back.sv
// ----------------------------------------------------------------------------
// cdu_back
// Pipelined restoring divider for both face coordinates (an integer digit, then
// one quotient bit per stage), rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module cdu_back import cdu_pkg::*;
#(
    parameter int COMP_WIDTH  = 16,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_pop,
    input  cdu_tag_t               in_tag,
    input  logic [COMP_WIDTH:0]    in_dist,
    input  logic [COMP_WIDTH:0]    in_num_u,
    input  logic [COMP_WIDTH:0]    in_num_v,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output face_t                  face_index,
    output logic [COORD_WIDTH-1:0] coord_u,
    output logic [COORD_WIDTH-1:0] coord_v,
    output logic                   degenerate
);

    localparam int RW   = COMP_WIDTH + 1;
    localparam int QW   = COORD_WIDTH + 2;
    localparam int LAST = COORD_WIDTH;

    typedef logic [RW-1:0]          rem_t;
    typedef logic [QW-1:0]          quo_t;
    typedef logic [COORD_WIDTH-1:0] coord_t;

    localparam coord_t HALF_COORD = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic     vld_reg     [LAST+1];
    logic     vld_next    [LAST+1];
    cdu_tag_t tag_reg     [LAST+1];
    cdu_tag_t tag_next    [LAST+1];
    rem_t     dist_reg    [LAST+1];
    rem_t     dist_next   [LAST+1];
    rem_t     rem_u_reg   [LAST+1];
    rem_t     rem_u_next  [LAST+1];
    rem_t     rem_v_reg   [LAST+1];
    rem_t     rem_v_next  [LAST+1];
    quo_t     quo_u_reg   [LAST+1];
    quo_t     quo_u_next  [LAST+1];
    quo_t     quo_v_reg   [LAST+1];
    quo_t     quo_v_next  [LAST+1];

    logic     out_valid_reg;
    face_t    face_reg;
    coord_t   coord_u_reg, coord_v_reg;
    logic     deg_reg;
    logic     en;

    logic [RW+1:0] int_u, int_v;

    // Integer part of num/d, which lies in 0..2
    function automatic logic [RW+1:0] int_digit(input rem_t num, input rem_t divisor);
        rem_t          two_d;
        logic [RW+1:0] res;
        two_d = {divisor[RW-2:0], 1'b0};
        priority if (num >= two_d)
        begin
            res = {2'd2, rem_t'(num - two_d)};
        end
        else if (num >= divisor)
        begin
            res = {2'd1, rem_t'(num - divisor)};
        end
        else
        begin
            res = {2'd0, num};
        end
        return res;
    endfunction

    // One fractional quotient bit: shift, compare, restore
    function automatic logic [RW:0] frac_digit(input rem_t rem, input rem_t divisor);
        rem_t      shifted;
        logic [RW:0] res;
        shifted = {rem[RW-2:0], 1'b0};
        if (shifted >= divisor)
        begin
            res = {1'b1, rem_t'(shifted - divisor)};
        end
        else
        begin
            res = {1'b0, shifted};
        end
        return res;
    endfunction

    // Halve floor(num * 2^W / d), rounding half up, and saturate at full scale
    function automatic coord_t round_sat(input quo_t quo);
        quo_t                 inc;
        logic [COORD_WIDTH:0] r;
        inc = quo_t'(quo + 1'b1);
        r   = inc[QW-1:1];
        return r[COORD_WIDTH] ? '1 : r[COORD_WIDTH-1:0];
    endfunction

    // Whole pipeline moves when the output register is free or being taken
    assign en     = !out_valid_reg || m_tready;
    assign in_pop = en && in_valid;

    // Stage 0: integer digit from the queue head
    assign int_u         = int_digit(in_num_u, in_dist);
    assign int_v         = int_digit(in_num_v, in_dist);
    assign vld_next[0]   = in_valid;
    assign tag_next[0]   = in_tag;
    assign dist_next[0]  = in_dist;
    assign rem_u_next[0] = int_u[RW-1:0];
    assign rem_v_next[0] = int_v[RW-1:0];
    assign quo_u_next[0] = quo_t'(int_u[RW+1:RW]);
    assign quo_v_next[0] = quo_t'(int_v[RW+1:RW]);

    // Stages 1..LAST: one fractional bit each
    for (genvar k = 1; k <= LAST; k++)
    begin : g_stage
        logic [RW:0] step_u, step_v;

        assign step_u        = frac_digit(rem_u_reg[k-1], dist_reg[k-1]);
        assign step_v        = frac_digit(rem_v_reg[k-1], dist_reg[k-1]);
        assign vld_next[k]   = vld_reg[k-1];
        assign tag_next[k]   = tag_reg[k-1];
        assign dist_next[k]  = dist_reg[k-1];
        assign rem_u_next[k] = step_u[RW-1:0];
        assign rem_v_next[k] = step_v[RW-1:0];
        assign quo_u_next[k] = {quo_u_reg[k-1][QW-2:0], step_u[RW]};
        assign quo_v_next[k] = {quo_v_reg[k-1][QW-2:0], step_v[RW]};
    end

    // Stage valid bits and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
            out_valid_reg <= vld_reg[LAST];
        end
    end

    // Stage payload and output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                tag_reg[k]   <= tag_next[k];
                dist_reg[k]  <= dist_next[k];
                rem_u_reg[k] <= rem_u_next[k];
                rem_v_reg[k] <= rem_v_next[k];
                quo_u_reg[k] <= quo_u_next[k];
                quo_v_reg[k] <= quo_v_next[k];
            end
            face_reg    <= tag_reg[LAST].face;
            deg_reg     <= tag_reg[LAST].degenerate;
            coord_u_reg <= tag_reg[LAST].degenerate ? HALF_COORD : round_sat(quo_u_reg[LAST]);
            coord_v_reg <= tag_reg[LAST].degenerate ? HALF_COORD : round_sat(quo_v_reg[LAST]);
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign face_index = face_reg;
    assign coord_u    = coord_u_reg;
    assign coord_v    = coord_v_reg;
    assign degenerate = deg_reg;

endmodule

FILE: rtl/cdu_checker.sv
// ----------------------------------------------------------------------------
// cdu_checker
// Port-level checks on the results of the cube face selection block.
// ----------------------------------------------------------------------------
`include "cube_dir_to_face_uv_macros.svh"

module cdu_checker import cdu_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((3+2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic [0:0]                           m_tuser
);

    localparam logic [COORD_WIDTH-1:0] HALF_COORD = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [2:0]             out_face;
    logic [COORD_WIDTH-1:0] out_u, out_v;
    logic                   out_flat;

    assign out_face = m_tdata[2:0];
    assign out_u    = m_tdata[COORD_WIDTH+2:3];
    assign out_v    = m_tdata[2*COORD_WIDTH+2:COORD_WIDTH+3];
    assign out_flat = m_tuser[0];

    // Hold a stalled result
    `CDU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Degenerate results carry face -x and centered coordinates
    `CDU_ASSERT_IMPLY(a_degenerate_result, clk, rst_n, m_tvalid && out_flat, (out_face == FACE_NEG_X) && (out_u == HALF_COORD) && (out_v == HALF_COORD), "degenerate result has wrong face or coordinates")

    // Face index stays within the six faces
    `CDU_ASSERT_IMPLY(a_face_range, clk, rst_n, m_tvalid, out_face <= FACE_NEG_Z, "face index out of range")

endmodule

bind cube_dir_to_face_uv cdu_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_cdu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/face_uv_checker.sv
// ----------------------------------------------------------------------------
// face_uv_checker
// Watches both streams of the cube face block, predicts each result and
// compares it field by field against what leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module face_uv_checker import cdu_pkg::*;
#(
    parameter int COMP_WIDTH  = 16,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    input  logic                                         s_tready,
    // dir_x, dir_y, dir_z
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0]            s_tdata,
    input  logic                                         m_tvalid,
    input  logic                                         m_tready,
    // face_index, coord_u, coord_v
    input  logic [((3+2*COORD_WIDTH+7)/8)*8-1:0]         m_tdata,
    // degenerate
    input  logic [0:0]                                   m_tuser,
    output int                                           results_owed,
    output int                                           mismatches
);

    typedef struct {
        face_t                  face;
        logic [COORD_WIDTH-1:0] coord_u;
        logic [COORD_WIDTH-1:0] coord_v;
        logic                   degenerate;
    } face_uv_t;

    face_uv_t expected_faces[$];

    // Map n/m, clamped to [-1,1], onto [0, 2^COORD_WIDTH - 1], rounding half up
    function automatic logic [COORD_WIDTH-1:0] ratio_to_coord(longint n, longint m);
        longint span;
        longint num;
        longint full;
        longint q;
        span = (m < 0) ? -m : m;
        num  = (m < 0) ? -n : n;
        full = longint'(1) << COORD_WIDTH;
        if (num > span)
            num = span;
        if (num < -span)
            num = -span;
        q = ((num + span) * full + span) / (2 * span);
        if (q > full - 1)
            q = full - 1;
        return q[COORD_WIDTH-1:0];
    endfunction

    // Pick the face of the largest component and project the other two onto it
    function automatic face_uv_t predict_face_uv(logic [COMP_WIDTH-1:0] raw_x,
                                                 logic [COMP_WIDTH-1:0] raw_y,
                                                 logic [COMP_WIDTH-1:0] raw_z);
        face_uv_t res;
        longint   x;
        longint   y;
        longint   z;
        longint   ax;
        longint   ay;
        longint   az;
        longint   nu;
        longint   nv;
        longint   major;
        x  = longint'($signed(raw_x));
        y  = longint'($signed(raw_y));
        z  = longint'($signed(raw_z));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        res.degenerate = 1'b0;
        if (ax == 0 && ay == 0 && az == 0) begin
            res.face       = FACE_NEG_X;
            res.coord_u    = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
            res.coord_v    = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
            res.degenerate = 1'b1;
            return res;
        end
        // Ties go to x first, then y; a non-positive major picks the negative face
        if (ax >= ay && ax >= az) begin
            major    = x;
            nu       = z;
            nv       = (x > 0) ? y : -y;
            res.face = (x > 0) ? FACE_POS_X : FACE_NEG_X;
        end
        else if (ay >= az) begin
            major    = y;
            nu       = x;
            nv       = (y > 0) ? z : -z;
            res.face = (y > 0) ? FACE_POS_Y : FACE_NEG_Y;
        end
        else begin
            major    = z;
            nu       = -x;
            nv       = (z > 0) ? y : -y;
            res.face = (z > 0) ? FACE_POS_Z : FACE_NEG_Z;
        end
        res.coord_u = ratio_to_coord(nu, major);
        res.coord_v = ratio_to_coord(nv, major);
        return res;
    endfunction

    initial
    begin
        results_owed = 0;
        mismatches   = 0;
    end

    // Queue a prediction per input transaction, check each output transaction
    always @(posedge clk)
    begin
        face_uv_t         want;
        logic [2:0]       got_face;
        logic [COORD_WIDTH-1:0] got_u;
        logic [COORD_WIDTH-1:0] got_v;
        logic             in_fire;
        logic             out_fire;
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        if (in_fire)
            expected_faces.push_back(predict_face_uv(
                s_tdata[COMP_WIDTH-1:0],
                s_tdata[2*COMP_WIDTH-1:COMP_WIDTH],
                s_tdata[3*COMP_WIDTH-1:2*COMP_WIDTH]));
        if (out_fire) begin
            got_face = m_tdata[2:0];
            got_u    = m_tdata[3+COORD_WIDTH-1:3];
            got_v    = m_tdata[3+2*COORD_WIDTH-1:3+COORD_WIDTH];
            if (expected_faces.size() == 0) begin
                $display("%0t: unexpected result: face %0d u %0d v %0d degenerate %0b",
                         $time, got_face, got_u, got_v, m_tuser[0]);
                mismatches = mismatches + 1;
            end
            else begin
                want = expected_faces.pop_front();
                if (got_face !== want.face) begin
                    $display("%0t: face mismatch: expected %0d (%s), actual %0d",
                             $time, want.face, want.face.name(), got_face);
                    mismatches = mismatches + 1;
                end
                if (got_u !== want.coord_u) begin
                    $display("%0t: coord_u mismatch: expected %0d, actual %0d",
                             $time, want.coord_u, got_u);
                    mismatches = mismatches + 1;
                end
                if (got_v !== want.coord_v) begin
                    $display("%0t: coord_v mismatch: expected %0d, actual %0d",
                             $time, want.coord_v, got_v);
                    mismatches = mismatches + 1;
                end
                if (m_tuser[0] !== want.degenerate) begin
                    $display("%0t: degenerate mismatch: expected %0b, actual %0b",
                             $time, want.degenerate, m_tuser[0]);
                    mismatches = mismatches + 1;
                end
            end
        end
        // Update the owed count after the edge so the stimulus reads a stable value
        results_owed <= results_owed + int'(in_fire) - int'(out_fire);
    end

endmodule

FILE: tb/tb_cube_dir_to_face_uv.sv
// ----------------------------------------------------------------------------
// tb_cube_dir_to_face_uv
// Drives direction vectors into the cube face block and reports the verdict.
// Directed vectors cover axis extremes, zero, ties and saturation; random
// vectors follow with random stalls on both streams. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_cube_dir_to_face_uv;
    import cdu_pkg::*;

    localparam int COMP_WIDTH   = 16;
    localparam int COORD_WIDTH  = 16;
    localparam int IN_BITS      = ((3*COMP_WIDTH+7)/8)*8;
    localparam int OUT_BITS     = ((3+2*COORD_WIDTH+7)/8)*8;
    localparam int RANDOM_DIRS  = 1750;
    localparam int SETTLE_WAIT  = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;
    logic [0:0]          m_tuser;
    logic                steady;
    int                  results_owed;
    int                  mismatches;
    int                  cycle_count;

    cube_dir_to_face_uv #(
        .COMP_WIDTH  (COMP_WIDTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    face_uv_checker #(
        .COMP_WIDTH  (COMP_WIDTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .results_owed (results_owed),
        .mismatches   (mismatches)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result stream at random, except during the steady stretch
    always @(posedge clk)
    begin
        if (steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 13);
    end

    // Abort the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Clip a magnitude and sign into the component range
    function automatic logic [COMP_WIDTH-1:0] signed_comp(int mag, bit neg);
        int val;
        if (!neg && mag > 32767)
            mag = 32767;
        val = neg ? -mag : mag;
        return val[COMP_WIDTH-1:0];
    endfunction

    // Pick a component from the edges of the range
    function automatic logic [COMP_WIDTH-1:0] edge_comp();
        case ($urandom_range(6))
            0: return 16'sh8000;
            1: return 16'sh8001;
            2: return 16'shffff;
            3: return 16'sh0000;
            4: return 16'sh0001;
            5: return 16'sh7fff;
            default: return COMP_WIDTH'($urandom);
        endcase
    endfunction

    // Offer one direction, hold it until accepted, then maybe idle
    task automatic drive_dir(logic [COMP_WIDTH-1:0] x, logic [COMP_WIDTH-1:0] y,
                             logic [COMP_WIDTH-1:0] z);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Hold off the sender until every owed result has left the block
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Directions whose two or three largest magnitudes are equal
    task automatic drive_tied_dir();
        int                    mag;
        logic [COMP_WIDTH-1:0] a;
        logic [COMP_WIDTH-1:0] b;
        logic [COMP_WIDTH-1:0] c;
        logic [COMP_WIDTH-1:0] lesser;
        mag    = $urandom_range(32768);
        a      = signed_comp(mag, 1'($urandom_range(1)));
        b      = signed_comp(mag, 1'($urandom_range(1)));
        c      = signed_comp(mag, 1'($urandom_range(1)));
        lesser = signed_comp($urandom_range(mag), 1'($urandom_range(1)));
        case ($urandom_range(3))
            0: drive_dir(a, b, lesser);
            1: drive_dir(lesser, a, b);
            2: drive_dir(a, lesser, b);
            default: drive_dir(a, b, c);
        endcase
    endtask

    initial
    begin
        int kind;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        steady      = 1'b0;
        cycle_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Zero vector and axis extremes
        drive_dir(16'sd0, 16'sd0, 16'sd0);
        drive_dir(16'sd32767, 16'sd0, 16'sd0);
        drive_dir(-16'sd32768, 16'sd0, 16'sd0);
        drive_dir(16'sd0, 16'sd32767, 16'sd0);
        drive_dir(16'sd0, -16'sd32768, 16'sd0);
        drive_dir(16'sd0, 16'sd0, 16'sd32767);
        drive_dir(16'sd0, 16'sd0, -16'sd32768);
        drive_dir(16'sd1, 16'sd0, 16'sd0);
        drive_dir(-16'sd1, 16'sd0, 16'sd0);
        drive_dir(16'sd0, 16'sd0, -16'sd1);
        // Ties: x beats y and z, y beats z, sign of the winner picks the face
        drive_dir(16'sd100, 16'sd100, 16'sd100);
        drive_dir(16'sd100, -16'sd100, 16'sd50);
        drive_dir(-16'sd100, 16'sd100, 16'sd100);
        drive_dir(16'sd5, -16'sd7, 16'sd7);
        drive_dir(16'sd0, -16'sd1, 16'sd1);
        drive_dir(-16'sd32768, -16'sd32768, -16'sd32768);
        drive_dir(16'sd32767, 16'sd32767, -16'sd32768);
        // Minor equal to major: coordinate saturates at one or sits at zero
        drive_dir(16'sd16384, 16'sd16384, -16'sd16384);
        drive_dir(-16'sd16384, -16'sd16384, 16'sd16384);
        drive_dir(16'sd32767, -16'sd32767, 16'sd1);
        // Half-way quotients round up
        drive_dir(16'sd3, 16'sd1, 16'sd0);
        drive_dir(16'sd3, -16'sd1, 16'sd2);
        drive_dir(-16'sd3, 16'sd1, -16'sd2);
        drain_results();

        // Random directions, with a long stretch free of stalls
        for (int i = 0; i < RANDOM_DIRS; i++) begin
            steady = (i >= 600 && i < 1000);
            if (i == 1000)
                drain_results();
            kind = $urandom_range(99);
            if (kind < 50)
                drive_dir(COMP_WIDTH'($urandom), COMP_WIDTH'($urandom),
                          COMP_WIDTH'($urandom));
            else if (kind < 65)
                drive_dir(COMP_WIDTH'($urandom_range(8) - 4),
                          COMP_WIDTH'($urandom_range(8) - 4),
                          COMP_WIDTH'($urandom_range(8) - 4));
            else if (kind < 90)
                drive_tied_dir();
            else
                drive_dir(edge_comp(), edge_comp(), edge_comp());
        end
        steady = 1'b0;

        // Wait out the pipeline, then report
        drain_results();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
